[rtl/core/wbp_pkg.sv]
// ----------------------------------------------------------------------------
// wbp_pkg
// shared types and constants of the waveform bit-plane plotter
// ----------------------------------------------------------------------------
`default_nettype none

package wbp_pkg;

  // sample-to-offset table
  localparam int TABLE_ENTRIES = 256;
  localparam int TBL_HALF      = TABLE_ENTRIES / 2;   // largest sample magnitude
  localparam int TBL_DEPTH     = TBL_HALF + 1;        // magnitudes 0..TBL_HALF
  localparam int TBL_AW        = $clog2(TBL_DEPTH);
  localparam int TCNT_W        = $clog2(TBL_DEPTH + 1);

  // field widths
  localparam int SMP_W    = 8;
  localparam int HH_W     = 8;
  localparam int PITCH_W  = 8;
  localparam int STRIDE_W = 8;
  localparam int CNT_W    = 16;
  localparam int ADDR_W   = 24;
  localparam int MASK_W   = 16;
  localparam int BIT_W    = $clog2(MASK_W);
  localparam int OFS_W    = 16;
  localparam int ACC_W    = 16;

  localparam logic [MASK_W-1:0] MASK_LEFT = 16'h8000;
  localparam logic [ACC_W-1:0]  ACC_WRAP  = 16'd128;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_HEIGHT   = 3'd0,
    REG_ROW_PITCH     = 3'd1,
    REG_SAMPLE_STRIDE = 3'd2,
    REG_POINT_COUNT   = 3'd3,
    REG_SCREEN_BASE   = 3'd4
  } cfg_reg_t;

  // controller to datapath
  typedef struct packed {
    logic build_restart;
    logic build_en;
    logic accept;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic tbl_wr;
    logic build_done;
    logic point;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/core/wbp_ctrl.sv]
// ----------------------------------------------------------------------------
// wbp_ctrl
// table rebuild sequencing and request handshake control
// ----------------------------------------------------------------------------
`default_nettype none

module wbp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  wbp_pkg::dp_status_t status,
  output wbp_pkg::ctrl_cmd_t  cmd
);
  import wbp_pkg::*;

  typedef enum logic [1:0] {
    ST_BUILD = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   s1_valid_r, s1_valid_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free, s1_adv, accept;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_BUILD: begin
        if (status.build_done && !status.tbl_wr) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (status.tbl_wr) state_nxt = ST_BUILD;
      end
      default: state_nxt = ST_BUILD;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = (state_r != ST_RUN) || (s1_valid_r && !out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) s1_valid_nxt = status.point;
    else if (s1_adv) s1_valid_nxt = 1'b0;
    else s1_valid_nxt = s1_valid_r;

    if (s1_adv) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_BUILD;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign cmd.build_restart = status.tbl_wr;
  assign cmd.build_en      = (state_r == ST_BUILD) && !status.tbl_wr;
  assign cmd.accept        = accept;
  assign cmd.out_load      = s1_adv;

endmodule

`default_nettype wire

[rtl/core/wbp_dp.sv]
// ----------------------------------------------------------------------------
// wbp_dp
// config registers, offset table, plot position state and address path
// ----------------------------------------------------------------------------
`default_nettype none

module wbp_dp #(
  parameter int PLANE_WORDS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [wbp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wbp_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [wbp_pkg::SMP_W-1:0]     in_sample,
  input  logic                                 in_restart,
  input  wbp_pkg::ctrl_cmd_t                   cmd,
  output wbp_pkg::dp_status_t                  status,
  output logic [wbp_pkg::ADDR_W-1:0]           out_word_address,
  output logic [wbp_pkg::MASK_W-1:0]           out_pixel_mask,
  output logic                                 out_last_point
);
  import wbp_pkg::*;

  // config registers
  logic [HH_W-1:0]     half_height_r;
  logic [PITCH_W-1:0]  row_pitch_r;
  logic [STRIDE_W-1:0] sample_stride_r;
  logic [CNT_W-1:0]    point_count_r;
  logic [ADDR_W-1:0]   screen_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_height_r   <= HH_W'(64);
      row_pitch_r     <= PITCH_W'(160);
      sample_stride_r <= STRIDE_W'(1);
      point_count_r   <= CNT_W'(1);
      screen_base_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_HEIGHT:   half_height_r   <= cfg_data[HH_W-1:0];
        REG_ROW_PITCH:     row_pitch_r     <= cfg_data[PITCH_W-1:0];
        REG_SAMPLE_STRIDE: sample_stride_r <= cfg_data[STRIDE_W-1:0];
        REG_POINT_COUNT:   point_count_r   <= cfg_data[CNT_W-1:0];
        REG_SCREEN_BASE:   screen_base_r   <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign status.tbl_wr = cfg_we &&
    (cfg_index == REG_HALF_HEIGHT || cfg_index == REG_ROW_PITCH);

  // table builder, one magnitude per cycle
  logic [TCNT_W-1:0] t_r;
  logic [ACC_W-1:0]  acc_r, acc_nxt, acc_sum;
  logic [OFS_W-1:0]  inc_r, inc_nxt;

  assign acc_sum = acc_r + ACC_W'(half_height_r);

  always_comb begin
    if (t_r == '0) begin
      acc_nxt = '0;
      inc_nxt = '0;
    end else if (acc_sum >= ACC_WRAP) begin
      acc_nxt = acc_sum - ACC_WRAP;
      inc_nxt = inc_r + OFS_W'(row_pitch_r);
    end else begin
      acc_nxt = acc_sum;
      inc_nxt = inc_r;
    end
  end

  assign status.build_done = (t_r == TCNT_W'(TBL_HALF));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r   <= '0;
      acc_r <= '0;
      inc_r <= '0;
    end else if (cmd.build_restart) begin
      t_r <= '0;
    end else if (cmd.build_en) begin
      acc_r <= acc_nxt;
      inc_r <= inc_nxt;
      if (!status.build_done) t_r <= t_r + 1'b1;
    end
  end

  // offset magnitude per sample magnitude
  logic [OFS_W-1:0]  tbl_mem [TBL_DEPTH];
  logic [OFS_W-1:0]  rd_r;
  logic [TBL_AW-1:0] mag;

  assign mag = in_sample[SMP_W-1] ? TBL_AW'(-in_sample) : TBL_AW'(in_sample);

  always_ff @(posedge clk) begin
    if (cmd.build_en) tbl_mem[t_r[TBL_AW-1:0]] <= inc_nxt;
    if (cmd.accept) rd_r <= tbl_mem[mag];
  end

  // plot position state
  logic [BIT_W-1:0]    bit_r, eff_bit, bit_inc;
  logic [ADDR_W-1:0]   group_r, eff_group;
  logic [CNT_W-1:0]    pts_r, eff_pts, pts_inc, limit;
  logic [STRIDE_W-1:0] skip_r, eff_skip, stride_m1;
  logic                done_r, eff_done, last;

  assign eff_bit   = in_restart ? '0   : bit_r;
  assign eff_group = in_restart ? '0   : group_r;
  assign eff_pts   = in_restart ? '0   : pts_r;
  assign eff_skip  = in_restart ? '0   : skip_r;
  assign eff_done  = in_restart ? 1'b0 : done_r;

  assign status.point = !eff_done && (eff_skip == '0);

  assign bit_inc   = eff_bit + 1'b1;
  assign pts_inc   = eff_pts + 1'b1;
  assign limit     = (point_count_r == '0) ? CNT_W'(1) : point_count_r;
  assign last      = pts_inc >= limit;
  assign stride_m1 = (sample_stride_r == '0) ? '0 : sample_stride_r - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r   <= '0;
      group_r <= '0;
      pts_r   <= '0;
      skip_r  <= '0;
      done_r  <= 1'b0;
    end else if (cmd.accept) begin
      bit_r   <= eff_bit;
      group_r <= eff_group;
      pts_r   <= eff_pts;
      skip_r  <= eff_skip;
      done_r  <= eff_done;
      if (!eff_done) begin
        if (eff_skip != '0) begin
          skip_r <= eff_skip - 1'b1;
        end else begin
          bit_r  <= bit_inc;
          pts_r  <= pts_inc;
          skip_r <= stride_m1;
          done_r <= last;
          if (bit_inc == '0) group_r <= eff_group + ADDR_W'(PLANE_WORDS);
        end
      end
    end
  end

  // point stage, waits for the table read
  logic              s1_neg_r, s1_last_r;
  logic [ADDR_W-1:0] s1_group_r;
  logic [MASK_W-1:0] s1_mask_r;

  always_ff @(posedge clk) begin
    if (cmd.accept && status.point) begin
      s1_neg_r   <= in_sample[SMP_W-1];
      s1_group_r <= eff_group;
      s1_mask_r  <= MASK_LEFT >> eff_bit;
      s1_last_r  <= last;
    end
  end

  // signed byte offset halved to words, sign extended
  logic [OFS_W-1:0]  ofs;
  logic [ADDR_W-1:0] half_ext;

  assign ofs      = s1_neg_r ? (~rd_r + 1'b1) : rd_r;
  assign half_ext = {{(ADDR_W-OFS_W+1){ofs[OFS_W-1]}}, ofs[OFS_W-1:1]};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word_address <= screen_base_r + s1_group_r + half_ext;
      out_pixel_mask   <= s1_mask_r;
      out_last_point   <= s1_last_r;
    end
  end

endmodule

`default_nettype wire

[rtl/core/waveform_bitplane_plotter.sv]
// ----------------------------------------------------------------------------
// waveform_bitplane_plotter
// plots signed samples as one-hot OR-writes on an interleaved bit-plane screen
// ----------------------------------------------------------------------------
// path: a plotted sample goes through the point stage, then the output register
// throughput: one sample request per cycle unless stalled, set by the
//   single-port offset table (one read per cycle) and its two-stage point path
// reset: synchronous; after reset, and after each write of half_height or
//   row_pitch, the table is rebuilt while in_stall stays high
`default_nettype none

module waveform_bitplane_plotter #(
  parameter int PLANE_WORDS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [wbp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wbp_pkg::CFG_DATA_W-1:0]       cfg_data,
  // sample requests
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [wbp_pkg::SMP_W-1:0]     in_sample,
  input  logic                                 in_restart,
  // pixel write requests
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [wbp_pkg::ADDR_W-1:0]           out_word_address,
  output logic [wbp_pkg::MASK_W-1:0]           out_pixel_mask,
  output logic                                 out_last_point
);
  import wbp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // controller: rebuild sequencing, point stage and output register valids
  wbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: registers, offset table, position counters, address adder
  wbp_dp #(
    .PLANE_WORDS (PLANE_WORDS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_sample        (in_sample),
    .in_restart       (in_restart),
    .cmd              (cmd),
    .status           (status),
    .out_word_address (out_word_address),
    .out_pixel_mask   (out_pixel_mask),
    .out_last_point   (out_last_point)
  );

  // a pending pixel write always carries exactly one pixel
  a_mask_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot(out_pixel_mask))
    else $error("pixel mask not one-hot");

  // a scale or pitch write blocks samples while the table is rebuilt
  a_rebuild_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $past(status.tbl_wr) |-> in_stall)
    else $error("sample taken during table rebuild");

  // no sample is taken right after reset, the table is not built yet
  a_reset_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> in_stall)
    else $error("sample taken before table built");

endmodule

`default_nettype wire
